// ----- hw/rtl/zone_bitmap_allocator_macros.svh -----
// assertion macros for the zone bitmap allocator
// used by the top level, needs nothing else
`ifndef ZONE_BITMAP_ALLOCATOR_MACROS_SVH
`define ZONE_BITMAP_ALLOCATOR_MACROS_SVH

// same-cycle implication
`define ZBA_ASSERT_NOW(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error(msg);

// next-cycle implication
`define ZBA_ASSERT_NEXT(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error(msg);

`endif

// ----- hw/rtl/zba_pkg.sv -----
// shared constants and helpers for the zone bitmap allocator
// no dependencies
package zba_pkg;

   localparam int MAP_BITS_DEFAULT = 65536;
   localparam int WORD_W           = 32;
   localparam int ZONE_W           = 32;
   localparam int BIU_W            = 17;
   localparam int STATUS_W         = 2;
   localparam int CSR_IDX_W        = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_FIRST_DATA_ZONE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ZONE_COUNT      = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BITS_IN_USE     = 2'd2;

   localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] ST_NO_SPACE = 2'd1;
   localparam logic [STATUS_W-1:0] ST_RANGE    = 2'd2;

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   localparam logic [ZONE_W-1:0] FDZ_RESET = 32'd1;
   localparam logic [ZONE_W-1:0] ZC_RESET  = 32'd0;
   localparam logic [BIU_W-1:0]  BIU_RESET = 17'd65536;

   // index of the lowest set bit
   function automatic logic [4:0] lowest_set(input logic [WORD_W-1:0] v);
      logic [4:0] r;
      r = 5'd0;
      for (int i = WORD_W - 1; i >= 0; i--) begin
         if (v[i]) begin
            r = 5'(i);
         end
      end
      return r;
   endfunction

endpackage

// ----- hw/rtl/zba_map_store.sv -----
// bitmap store: one write port, one read port with registered data
// depends on zba_pkg
module zba_map_store
   import zba_pkg::*;
#(
   parameter int WORDS = MAP_BITS_DEFAULT / WORD_W
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(WORDS)-1:0] wr_addr,
   input  logic [WORD_W-1:0]        wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(WORDS)-1:0] rd_addr,
   output logic [WORD_W-1:0]        rd_data
);

   logic [WORD_W-1:0] mem [WORDS];
   logic [WORD_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hw/rtl/zone_bitmap_allocator.sv -----
// First-fit zone allocator over a free-zone bitmap of MAP_BITS bits (a power of two,
// 64 to 1048576) held in one synchronous memory of MAP_BITS/32 words. After reset a
// clearing pass writes every word to zero with req_ready low; csr writes are taken
// throughout. Bit index b stands for zone number fdz - 1 + b, where fdz is the first
// data zone register. An allocate streams the in-use words through the single read port
// at one word a cycle up to the first one with a clear bit, then runs the zone-count
// check of the byte group. A free reads the word that holds the zone's bit and writes it
// back with the bit cleared; a zone out of range is answered without a read. One
// transaction is worked on at a time; a finished result waits in the rsp register while
// the next request is accepted.
`include "zone_bitmap_allocator_macros.svh"

module zone_bitmap_allocator
   import zba_pkg::*;
#(
   parameter int MAP_BITS = MAP_BITS_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic                 req_operation,
   input  logic [ZONE_W-1:0]    req_zone_to_free,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [ZONE_W-1:0]    rsp_zone_number,
   output logic [STATUS_W-1:0]  rsp_status,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [ZONE_W-1:0]    csr_wdata
);

   localparam int MAP_WORDS = MAP_BITS / WORD_W;
   localparam int AW        = $clog2(MAP_WORDS);
   localparam int BIT_W     = AW + 5;
   localparam int LIM_W     = (BIT_W + 1 > BIU_W) ? BIT_W + 1 : BIU_W;
   localparam int NW_W      = LIM_W - 5;

   localparam logic [2:0] S_CLEAR = 3'd0;
   localparam logic [2:0] S_IDLE  = 3'd1;
   localparam logic [2:0] S_SCAN  = 3'd2;
   localparam logic [2:0] S_ZCHK  = 3'd3;
   localparam logic [2:0] S_FCHK  = 3'd4;
   localparam logic [2:0] S_FWAIT = 3'd5;
   localparam logic [2:0] S_DONE  = 3'd6;

   // configuration
   logic [ZONE_W-1:0] fdz_ff, zc_ff;
   logic [BIU_W-1:0]  biu_ff;

   // control
   logic [2:0]        state_ff, state_in;
   logic [AW:0]       addr_ff, addr_in;
   logic              rd_pend_ff, rd_pend_in;
   logic [AW-1:0]     rd_word_ff, rd_word_in;
   logic              rsp_valid_ff, rsp_valid_in;

   // payload
   logic [ZONE_W-1:0]   zone_free_ff, zone_free_in;
   logic [BIT_W-1:0]    bit_ff, bit_in;
   logic [WORD_W-1:0]   word_ff, word_in;
   logic [2:0]          kcnt_ff, kcnt_in;
   logic [ZONE_W-1:0]   res_zone_ff, res_zone_in;
   logic [STATUS_W-1:0] res_status_ff, res_status_in;
   logic [ZONE_W-1:0]   rsp_zone_ff;
   logic [STATUS_W-1:0] rsp_status_ff;

   // memory port
   logic              mem_we, mem_re;
   logic [AW-1:0]     mem_waddr, mem_raddr;
   logic [WORD_W-1:0] mem_wdata, mem_rdata;

   logic [LIM_W-1:0]  biu_ext, lim;
   logic [NW_W-1:0]   nwords, lim_word, word_ext;
   logic              issue;
   logic [WORD_W-1:0] valid_mask, free_bits;
   logic [4:0]        hit_pos;
   logic              word_below, word_at;
   logic [BIT_W-1:0]  k_idx;
   logic [ZONE_W-1:0] z_chk, b_free;
   logic              req_fire, rsp_load;

   zba_map_store #(.WORDS(MAP_WORDS)) u_store (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_en   (mem_re),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         fdz_ff <= FDZ_RESET;
         zc_ff  <= ZC_RESET;
         biu_ff <= BIU_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_FIRST_DATA_ZONE: fdz_ff <= csr_wdata;
            CSR_ZONE_COUNT:      zc_ff  <= csr_wdata;
            CSR_BITS_IN_USE:     biu_ff <= csr_wdata[BIU_W-1:0];
            default: ;
         endcase
      end
   end

   // in-use limit clamped to the store
   always_comb begin
      biu_ext  = LIM_W'(biu_ff);
      lim      = (biu_ext > LIM_W'(MAP_BITS)) ? LIM_W'(MAP_BITS) : biu_ext;
      nwords   = NW_W'((lim + LIM_W'(31)) >> 5);
      lim_word = lim[LIM_W-1:5];
   end

   // word scan
   always_comb begin
      issue      = (NW_W'(addr_ff) < nwords);
      word_ext   = NW_W'(rd_word_ff);
      word_below = (word_ext < lim_word);
      word_at    = (word_ext == lim_word);
      for (int j = 0; j < WORD_W; j++) begin
         valid_mask[j] = word_below || (word_at && (5'(j) < lim[4:0]));
      end
      free_bits = ~mem_rdata & valid_mask;
      hit_pos   = lowest_set(free_bits);
   end

   assign k_idx    = {bit_ff[BIT_W-1:3], kcnt_ff};
   assign z_chk    = fdz_ff + ZONE_W'(k_idx) - ZONE_W'(1);
   assign b_free   = zone_free_ff - fdz_ff + ZONE_W'(1);
   assign req_fire = req_valid && req_ready;
   assign rsp_load = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      state_in      = state_ff;
      addr_in       = addr_ff;
      rd_pend_in    = 1'b0;
      rd_word_in    = addr_ff[AW-1:0];
      zone_free_in  = zone_free_ff;
      bit_in        = bit_ff;
      word_in       = word_ff;
      kcnt_in       = kcnt_ff;
      res_zone_in   = res_zone_ff;
      res_status_in = res_status_ff;
      mem_we        = 1'b0;
      mem_waddr     = addr_ff[AW-1:0];
      mem_wdata     = '0;
      mem_re        = 1'b0;
      mem_raddr     = addr_ff[AW-1:0];
      unique case (state_ff)
         S_CLEAR: begin
            mem_we  = 1'b1;
            addr_in = addr_ff + (AW+1)'(1);
            if (addr_ff[AW-1:0] == AW'(MAP_WORDS - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_fire) begin
               addr_in      = '0;
               zone_free_in = req_zone_to_free;
               state_in     = (req_operation == OP_FREE) ? S_FCHK : S_SCAN;
            end
         end
         S_SCAN: begin
            mem_re     = issue;
            rd_pend_in = issue;
            if (issue) begin
               addr_in = addr_ff + (AW+1)'(1);
            end
            if (rd_pend_ff && (free_bits != '0)) begin
               bit_in   = {rd_word_ff, hit_pos};
               word_in  = mem_rdata | (WORD_W'(1) << hit_pos);
               kcnt_in  = 3'd0;
               state_in = S_ZCHK;
            end else if (!rd_pend_ff && !issue) begin
               res_zone_in   = '0;
               res_status_in = ST_NO_SPACE;
               state_in      = S_DONE;
            end
         end
         S_ZCHK: begin
            if (z_chk >= zc_ff) begin
               res_zone_in   = '0;
               res_status_in = ST_NO_SPACE;
               state_in      = S_DONE;
            end else if (kcnt_ff == bit_ff[2:0]) begin
               mem_we        = 1'b1;
               mem_waddr     = bit_ff[BIT_W-1:5];
               mem_wdata     = word_ff;
               res_zone_in   = z_chk;
               res_status_in = ST_OK;
               state_in      = S_DONE;
            end else begin
               kcnt_in = kcnt_ff + 3'd1;
            end
         end
         S_FCHK: begin
            bit_in      = b_free[BIT_W-1:0];
            res_zone_in = '0;
            if ((zone_free_ff < fdz_ff) || (b_free >= ZONE_W'(lim))) begin
               res_status_in = ST_RANGE;
               state_in      = S_DONE;
            end else begin
               mem_re    = 1'b1;
               mem_raddr = b_free[BIT_W-1:5];
               state_in  = S_FWAIT;
            end
         end
         S_FWAIT: begin
            mem_we        = 1'b1;
            mem_waddr     = bit_ff[BIT_W-1:5];
            mem_wdata     = mem_rdata & ~(WORD_W'(1) << bit_ff[4:0]);
            res_status_in = ST_OK;
            state_in      = S_DONE;
         end
         S_DONE: begin
            if (rsp_load) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         addr_ff      <= '0;
         rd_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         addr_ff      <= addr_in;
         rd_pend_ff   <= rd_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_word_ff    <= rd_word_in;
      zone_free_ff  <= zone_free_in;
      bit_ff        <= bit_in;
      word_ff       <= word_in;
      kcnt_ff       <= kcnt_in;
      res_zone_ff   <= res_zone_in;
      res_status_ff <= res_status_in;
      if (rsp_load) begin
         rsp_zone_ff   <= res_zone_ff;
         rsp_status_ff <= res_status_ff;
      end
   end

   assign req_ready       = (state_ff == S_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_zone_number = rsp_zone_ff;
   assign rsp_status      = rsp_status_ff;

   `ZBA_ASSERT_NOW(a_clear_blocks_req, clock, reset, state_ff == S_CLEAR, !req_ready, "request taken during clear")
   `ZBA_ASSERT_NEXT(a_accept_leaves_idle, clock, reset, req_fire, state_ff != S_IDLE, "accepted transaction not started")
   `ZBA_ASSERT_NOW(a_no_write_in_scan, clock, reset, state_ff == S_SCAN, !mem_we, "bitmap written during scan")
   `ZBA_ASSERT_NOW(a_fail_zone_zero, clock, reset, rsp_valid && (rsp_status != ST_OK), rsp_zone_number == '0, "failed transaction with nonzero zone")

endmodule
